// File: hdl/mib_pkg.sv
// ----------------------------------------------------------------------------
// mib_pkg
// Shared types and constants for the MSR intercept bitmap manager: operation
// codes, bitmap geometry, MSR ranges, filter bits and controller interfaces.
// ----------------------------------------------------------------------------
package mib_pkg;

  // default memory word width (power of two, 8 to 64)
  localparam int unsigned MEM_WORD_BITS_DEF = 64;

  // one half of the bitmap (read or write) holds 16384 bits
  localparam int unsigned HALF_BITS  = 16384;
  localparam int unsigned HALF_IDX_W = 14;

  // operation codes
  localparam logic [2:0] OP_SET    = 3'd0;
  localparam logic [2:0] OP_CLEAR  = 3'd1;
  localparam logic [2:0] OP_ALL    = 3'd2;
  localparam logic [2:0] OP_RESET  = 3'd3;
  localparam logic [2:0] OP_LOOKUP = 3'd4;

  // msr ranges: low msrs have bits 31:13 zero, high msrs 0xC0000000 >> 13
  localparam logic [18:0] MSR_LOW_PAGE  = 19'h00000;
  localparam logic [18:0] MSR_HIGH_PAGE = 19'h60000;

  // bits left clear after intercept all, as bit index inside one half
  localparam logic [HALF_IDX_W-1:0] FILT_HIGH_102 = 14'h2102;
  localparam logic [HALF_IDX_W-1:0] FILT_LOW_E7   = 14'h00E7;
  localparam logic [HALF_IDX_W-1:0] FILT_LOW_E8   = 14'h00E8;
  localparam logic [HALF_IDX_W-1:0] FILT_LOW_48   = 14'h0048;
  localparam logic [HALF_IDX_W-1:0] FILT_LOW_49   = 14'h0049;

  // controller states
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACCESS,
    ST_UPDATE,
    ST_REJECT,
    ST_SWEEP
  } mib_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic mem_read;
    logic bit_write;
    logic sweep_step;
    logic clear_all;
    logic reply_reject;
    logic reply_done;
  } mib_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic reject;
    logic is_sweep;
    logic sweep_last;
  } mib_stat_t;

endpackage

// File: hdl/mib_ctrl.sv
// ----------------------------------------------------------------------------
// mib_ctrl
// Controller for the intercept bitmap: sequences the clearing pass after
// reset, read-modify-write of single bits, and whole-half sweeps.
// ----------------------------------------------------------------------------
module mib_ctrl
  import mib_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  mib_stat_t stat,
  output logic      busy,
  output mib_cmd_t  cmd
);

  mib_state_t state_r;
  mib_state_t state_nxt;
  logic       take;

  // a new transaction is taken in any state that is not busy
  assign take = start && !busy;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_ACCESS: begin
        state_nxt = ST_UPDATE;
      end
      ST_SWEEP: begin
        if (stat.sweep_last) state_nxt = ST_IDLE;
      end
      ST_IDLE, ST_UPDATE, ST_REJECT: begin
        if (take) begin
          if (stat.reject) begin
            state_nxt = ST_REJECT;
          end else if (stat.is_sweep) begin
            state_nxt = ST_SWEEP;
          end else begin
            state_nxt = ST_ACCESS;
          end
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // outputs
  always_comb begin
    busy = 1'b0;
    cmd  = '0;
    case (state_r)
      ST_CLEAR: begin
        busy           = 1'b1;
        cmd.sweep_step = 1'b1;
        cmd.clear_all  = 1'b1;
      end
      ST_ACCESS: begin
        busy         = 1'b1;
        cmd.mem_read = 1'b1;
      end
      ST_SWEEP: begin
        busy           = 1'b1;
        cmd.sweep_step = 1'b1;
        cmd.reply_done = stat.sweep_last;
      end
      ST_UPDATE: begin
        cmd.bit_write  = 1'b1;
        cmd.reply_done = 1'b1;
        cmd.capture    = start;
      end
      ST_REJECT: begin
        cmd.reply_reject = 1'b1;
        cmd.capture      = start;
      end
      ST_IDLE: begin
        cmd.capture = start;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

// File: hdl/mib_datapath.sv
// ----------------------------------------------------------------------------
// mib_datapath
// Request decode, captured request, two bitmap banks (read half and write
// half), sweep counter and result registers.
// ----------------------------------------------------------------------------
module mib_datapath
  import mib_pkg::*;
#(
  parameter int unsigned MEM_WORD_BITS = MEM_WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  mib_cmd_t    cmd,
  output mib_stat_t   stat,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_msr_number,
  input  logic        in_read_select,
  input  logic        in_write_select,
  output logic        out_valid,
  output logic        out_status,
  output logic        out_read_intercept,
  output logic        out_write_intercept
);

  localparam int unsigned LW         = $clog2(MEM_WORD_BITS);
  localparam int unsigned HALF_WORDS = HALF_BITS / MEM_WORD_BITS;
  localparam int unsigned AW         = HALF_IDX_W - LW;

  // memories: one bank per half
  logic [MEM_WORD_BITS-1:0] rd_mem [HALF_WORDS];
  logic [MEM_WORD_BITS-1:0] wr_mem [HALF_WORDS];
  logic [MEM_WORD_BITS-1:0] rd_q_r;
  logic [MEM_WORD_BITS-1:0] wr_q_r;

  // captured request
  logic [AW-1:0] cap_addr_r;
  logic [LW-1:0] cap_bit_r;
  logic          cap_rd_r;
  logic          cap_wr_r;
  logic          cap_set_r;
  logic          cap_write_r;
  logic          cap_lookup_r;
  logic          cap_fill_r;

  logic [AW-1:0] sweep_addr_r;

  logic                  out_valid_r;
  logic                  out_status_r;
  logic                  out_rd_r;
  logic                  out_wr_r;

  // decode
  logic                  in_low;
  logic                  in_high;
  logic                  bit_op;
  logic                  sweep_op;
  logic [HALF_IDX_W-1:0] half_idx;

  always_comb begin
    in_low   = (in_msr_number[31:13] == MSR_LOW_PAGE);
    in_high  = (in_msr_number[31:13] == MSR_HIGH_PAGE);
    bit_op   = in_operation inside {OP_SET, OP_CLEAR, OP_LOOKUP};
    sweep_op = in_operation inside {OP_ALL, OP_RESET};
    half_idx = {in_high, in_msr_number[12:0]};
    stat.reject = !(in_read_select || in_write_select) ||
                  (bit_op && !(in_low || in_high)) ||
                  !(bit_op || sweep_op);
    stat.is_sweep   = sweep_op;
    stat.sweep_last = (sweep_addr_r == AW'(HALF_WORDS - 1));
  end

  // capture the request when it is taken
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cap_addr_r   <= half_idx[HALF_IDX_W-1:LW];
      cap_bit_r    <= half_idx[LW-1:0];
      cap_rd_r     <= in_read_select;
      cap_wr_r     <= in_write_select;
      cap_set_r    <= (in_operation == OP_SET);
      cap_write_r  <= (in_operation == OP_SET) || (in_operation == OP_CLEAR);
      cap_lookup_r <= (in_operation == OP_LOOKUP);
      cap_fill_r   <= (in_operation == OP_ALL);
    end
  end

  // sweep address, wraps back to zero after the last word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_addr_r <= '0;
    end else if (cmd.sweep_step) begin
      sweep_addr_r <= sweep_addr_r + AW'(1);
    end
  end

  // fill words for intercept all, with the filter bits left clear
  logic [MEM_WORD_BITS-1:0] rd_fill;
  logic [MEM_WORD_BITS-1:0] wr_fill;

  always_comb begin
    rd_fill = '1;
    wr_fill = '1;
    if (sweep_addr_r == FILT_HIGH_102[HALF_IDX_W-1:LW]) begin
      rd_fill[FILT_HIGH_102[LW-1:0]] = 1'b0;
      wr_fill[FILT_HIGH_102[LW-1:0]] = 1'b0;
    end
    if (sweep_addr_r == FILT_LOW_E7[HALF_IDX_W-1:LW]) begin
      rd_fill[FILT_LOW_E7[LW-1:0]] = 1'b0;
      wr_fill[FILT_LOW_E7[LW-1:0]] = 1'b0;
    end
    if (sweep_addr_r == FILT_LOW_E8[HALF_IDX_W-1:LW]) begin
      rd_fill[FILT_LOW_E8[LW-1:0]] = 1'b0;
      wr_fill[FILT_LOW_E8[LW-1:0]] = 1'b0;
    end
    if (sweep_addr_r == FILT_LOW_48[HALF_IDX_W-1:LW]) begin
      wr_fill[FILT_LOW_48[LW-1:0]] = 1'b0;
    end
    if (sweep_addr_r == FILT_LOW_49[HALF_IDX_W-1:LW]) begin
      wr_fill[FILT_LOW_49[LW-1:0]] = 1'b0;
    end
  end

  // write port control for both banks
  logic                     rd_we;
  logic                     wr_we;
  logic [AW-1:0]            mem_waddr;
  logic [MEM_WORD_BITS-1:0] rd_wdata;
  logic [MEM_WORD_BITS-1:0] wr_wdata;
  logic                     use_fill;

  always_comb begin
    use_fill  = cap_fill_r && !cmd.clear_all;
    mem_waddr = cmd.sweep_step ? sweep_addr_r : cap_addr_r;
    rd_we     = cmd.sweep_step ? (cmd.clear_all || cap_rd_r)
                               : (cmd.bit_write && cap_write_r && cap_rd_r);
    wr_we     = cmd.sweep_step ? (cmd.clear_all || cap_wr_r)
                               : (cmd.bit_write && cap_write_r && cap_wr_r);
    if (cmd.sweep_step) begin
      rd_wdata = use_fill ? rd_fill : '0;
      wr_wdata = use_fill ? wr_fill : '0;
    end else begin
      rd_wdata = rd_q_r;
      wr_wdata = wr_q_r;
      rd_wdata[cap_bit_r] = cap_set_r;
      wr_wdata[cap_bit_r] = cap_set_r;
    end
  end

  // read bank
  always_ff @(posedge clk) begin
    if (rd_we) begin
      rd_mem[mem_waddr] <= rd_wdata;
    end
    if (cmd.mem_read) begin
      rd_q_r <= rd_mem[cap_addr_r];
    end
  end

  // write bank
  always_ff @(posedge clk) begin
    if (wr_we) begin
      wr_mem[mem_waddr] <= wr_wdata;
    end
    if (cmd.mem_read) begin
      wr_q_r <= wr_mem[cap_addr_r];
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.reply_done || cmd.reply_reject;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.reply_reject) begin
      out_status_r <= 1'b1;
      out_rd_r     <= 1'b0;
      out_wr_r     <= 1'b0;
    end else if (cmd.reply_done) begin
      out_status_r <= 1'b0;
      out_rd_r     <= cap_lookup_r && cap_rd_r && rd_q_r[cap_bit_r];
      out_wr_r     <= cap_lookup_r && cap_wr_r && wr_q_r[cap_bit_r];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_read_intercept  = out_rd_r;
  assign out_write_intercept = out_wr_r;

endmodule

// File: hdl/msr_intercept_bitmap_manager.sv
// ----------------------------------------------------------------------------
// msr_intercept_bitmap_manager
// Intercept bitmap for MSR reads and writes with set, clear, intercept all,
// reset half and lookup transactions.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken on the rising edge where start is high and busy is
//   low, with in_operation, in_msr_number, in_read_select, in_write_select.
//   Every transaction returns one result, shown for one cycle with out_valid
//   high; the receiver has no way to stall it.
//   Set, clear and lookup do a read-modify-write of one word per half: a
//   memory read state, then a write and reply state, in which a new
//   transaction can already be taken.
//   Rejected transactions answer with out_status 1.
//   Intercept all and reset half sweep each selected half, one word per
//   cycle, and reply once the last word is written.
//   After reset the block runs a clearing pass over both halves with busy
//   high throughout; no transaction is taken then.
//   MEM_WORD_BITS must be a power of two from 8 to 64.
// ----------------------------------------------------------------------------
module msr_intercept_bitmap_manager
  import mib_pkg::*;
#(
  parameter int unsigned MEM_WORD_BITS = MEM_WORD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_msr_number,
  input  logic        in_read_select,
  input  logic        in_write_select,
  output logic        out_valid,
  output logic        out_status,
  output logic        out_read_intercept,
  output logic        out_write_intercept
);

  mib_cmd_t  cmd;
  mib_stat_t stat;

  // controller
  mib_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath
  mib_datapath #(
    .MEM_WORD_BITS (MEM_WORD_BITS)
  ) u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .stat                (stat),
    .in_operation        (in_operation),
    .in_msr_number       (in_msr_number),
    .in_read_select      (in_read_select),
    .in_write_select     (in_write_select),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_read_intercept  (out_read_intercept),
    .out_write_intercept (out_write_intercept)
  );

  // a transaction with no half selected is answered as rejected
  a_no_half_rejects: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_read_select && !in_write_select)
      |-> ##2 (out_valid && out_status))
    else $error("transaction with no half selected not rejected");

  // a lookup of a low msr with a half selected answers done, not rejected
  a_lookup_done: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_operation == OP_LOOKUP) &&
     (in_read_select || in_write_select) && (in_msr_number[31:13] == 19'h0))
      |-> ##3 (out_valid && !out_status))
    else $error("lookup result missing or rejected");

  // rejected results never carry intercept bits
  a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> (!out_read_intercept && !out_write_intercept))
    else $error("rejected result carries intercept bits");

  // the block is busy in the cycle after reset for the clearing pass
  a_clear_after_reset: assert property (@(posedge clk)
    $rose(rst_n) |-> busy)
    else $error("block not busy after reset");

endmodule

// File: bench/msr_intercept_bitmap_manager_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// msr_intercept_bitmap_manager_test
// Self-checking bench for the MSR intercept bitmap manager. A scoreboard keeps
// its own copy of the 32768-bit intercept map, predicts the status and lookup
// bits of every accepted transaction and checks each result strobe in order.
// Stimulus is a short directed sequence followed by random transactions with
// sender idling at several rates.
// ----------------------------------------------------------------------------

// one result of the block
typedef struct packed {
  logic status;
  logic read_intercept;
  logic write_intercept;
} msr_reply_t;

// tracks the intercept map and the results still to come
class intercept_map_tracker;
  localparam int unsigned MAP_BITS = 32768;
  localparam int unsigned HALF_SPAN = 16384;
  localparam int unsigned HIGH_REGION = 8192;
  localparam int unsigned WRITE_HALF = 16384;
  localparam logic [31:0] LOW_LAST = 32'h0000_1FFF;
  localparam logic [31:0] HIGH_FIRST = 32'hC000_0000;
  localparam logic [31:0] HIGH_LAST = 32'hC000_1FFF;
  // msrs left unintercepted by intercept all
  localparam int unsigned KEEP_102 = 'h102;
  localparam int unsigned KEEP_E7 = 'hE7;
  localparam int unsigned KEEP_E8 = 'hE8;
  localparam int unsigned KEEP_48 = 'h48;
  localparam int unsigned KEEP_49 = 'h49;
  localparam int REPORT_LIMIT = 10;

  bit intercept_map [MAP_BITS];
  msr_reply_t pending_replies[$];
  int mismatches;

  function new();
    foreach (intercept_map[i]) intercept_map[i] = 1'b0;
    mismatches = 0;
  endfunction

  // write one value over a whole half
  function void fill_half(int unsigned base, bit value);
    for (int unsigned i = 0; i < HALF_SPAN; i++) intercept_map[base + i] = value;
  endfunction

  // apply an accepted transaction and queue its expected result
  function void note_request(logic [2:0] op, logic [31:0] msr, logic rd, logic wr);
    msr_reply_t reply;
    bit in_range;
    int unsigned rd_bit;
    int unsigned wr_bit;
    reply = '0;
    in_range = (msr <= LOW_LAST) || (msr >= HIGH_FIRST && msr <= HIGH_LAST);
    rd_bit = ((msr >= HIGH_FIRST) ? HIGH_REGION : 0) + int'(msr[12:0]);
    wr_bit = rd_bit + WRITE_HALF;
    if (!rd && !wr) begin
      reply.status = 1'b1;
    end else begin
      case (op)
        mib_pkg::OP_SET, mib_pkg::OP_CLEAR: begin
          if (!in_range) begin
            reply.status = 1'b1;
          end else begin
            if (rd) intercept_map[rd_bit] = (op == mib_pkg::OP_SET);
            if (wr) intercept_map[wr_bit] = (op == mib_pkg::OP_SET);
          end
        end
        mib_pkg::OP_LOOKUP: begin
          if (!in_range) begin
            reply.status = 1'b1;
          end else begin
            if (rd) reply.read_intercept = intercept_map[rd_bit];
            if (wr) reply.write_intercept = intercept_map[wr_bit];
          end
        end
        mib_pkg::OP_ALL: begin
          if (rd) begin
            fill_half(0, 1'b1);
            intercept_map[HIGH_REGION + KEEP_102] = 1'b0;
            intercept_map[KEEP_E7] = 1'b0;
            intercept_map[KEEP_E8] = 1'b0;
          end
          if (wr) begin
            fill_half(WRITE_HALF, 1'b1);
            intercept_map[WRITE_HALF + HIGH_REGION + KEEP_102] = 1'b0;
            intercept_map[WRITE_HALF + KEEP_E7] = 1'b0;
            intercept_map[WRITE_HALF + KEEP_E8] = 1'b0;
            intercept_map[WRITE_HALF + KEEP_48] = 1'b0;
            intercept_map[WRITE_HALF + KEEP_49] = 1'b0;
          end
        end
        mib_pkg::OP_RESET: begin
          if (rd) fill_half(0, 1'b0);
          if (wr) fill_half(WRITE_HALF, 1'b0);
        end
        default: reply.status = 1'b1;
      endcase
    end
    pending_replies.push_back(reply);
  endfunction

  function void note_mismatch(string what, msr_reply_t want, msr_reply_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display({"mismatch at %0t: %s: expected status %b read %b write %b, ",
                "got status %b read %b write %b"},
               $time, what, want.status, want.read_intercept, want.write_intercept,
               got.status, got.read_intercept, got.write_intercept);
  endfunction

  // compare a result with the oldest expectation
  function void check_reply(msr_reply_t got);
    msr_reply_t want;
    if (pending_replies.size() == 0) begin
      note_mismatch("result with nothing outstanding", '0, got);
      return;
    end
    want = pending_replies.pop_front();
    if (got !== want) note_mismatch("wrong result", want, got);
  endfunction
endclass

module msr_intercept_bitmap_manager_test;
  import mib_pkg::*;

  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS = 600;
  localparam logic [2:0] OP_FIRST_UNUSED = OP_LOOKUP + 3'd1;
  localparam logic [2:0] OP_LAST_UNUSED = 3'h7;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic [2:0] in_operation = '0;
  logic [31:0] in_msr_number = '0;
  logic in_read_select = 1'b0;
  logic in_write_select = 1'b0;
  logic busy;
  logic out_valid;
  logic out_status;
  logic out_read_intercept;
  logic out_write_intercept;

  intercept_map_tracker tracker = new();
  int unsigned sender_idle_pct = 0;
  int unsigned quiet_cycles = 0;

  // msrs that random transactions keep coming back to
  logic [31:0] msr_pool [16] = '{
    32'h0000_0000, 32'h0000_0001, 32'h0000_0010, 32'h0000_0048,
    32'h0000_0049, 32'h0000_00E7, 32'h0000_00E8, 32'h0000_0102,
    32'h0000_1000, 32'h0000_1FFF, 32'hC000_0000, 32'hC000_0080,
    32'hC000_0102, 32'hC000_0103, 32'hC000_1000, 32'hC000_1FFF
  };
  // edges of the two valid ranges, plus far out-of-range msrs
  logic [31:0] msr_edges [8] = '{
    32'h0000_1FFF, 32'h0000_2000, 32'hBFFF_FFFF, 32'hC000_0000,
    32'hC000_1FFF, 32'hC000_2000, 32'hFFFF_FFFF, 32'h8000_0000
  };

  msr_intercept_bitmap_manager uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_operation        (in_operation),
    .in_msr_number       (in_msr_number),
    .in_read_select      (in_read_select),
    .in_write_select     (in_write_select),
    .out_valid           (out_valid),
    .out_status          (out_status),
    .out_read_intercept  (out_read_intercept),
    .out_write_intercept (out_write_intercept)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // result check first, then note the transaction taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        tracker.check_reply(msr_reply_t'({out_status, out_read_intercept, out_write_intercept}));
      if (start && !busy)
        tracker.note_request(in_operation, in_msr_number, in_read_select, in_write_select);
    end
  end

  // watchdog on cycles with no transaction and no result
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("** msr_intercept_bitmap_manager: FAILED **");
      $finish;
    end
  end

  // random idle cycles after a transaction, with junk on the fields
  task automatic pause_sender();
    if ($urandom_range(0, 99) < sender_idle_pct) begin
      start <= 1'b0;
      in_operation <= 3'($urandom);
      in_msr_number <= $urandom;
      in_read_select <= 1'($urandom);
      in_write_select <= 1'($urandom);
      do @(posedge clk); while ($urandom_range(0, 99) < sender_idle_pct);
    end
  endtask

  // present one transaction and hold it until taken
  task automatic issue(logic [2:0] op, logic [31:0] msr, logic rd, logic wr);
    start <= 1'b1;
    in_operation <= op;
    in_msr_number <= msr;
    in_read_select <= rd;
    in_write_select <= wr;
    @(posedge clk);
    while (busy) @(posedge clk);
    pause_sender();
  endtask

  function automatic logic [31:0] pick_msr();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 50) return msr_pool[$urandom_range(0, 15)];
    if (pick < 60) return {19'h0, 13'($urandom)};
    if (pick < 70) return {19'h60000, 13'($urandom)};
    if (pick < 80) return msr_edges[$urandom_range(0, 7)];
    return $urandom;
  endfunction

  // mostly bit operations on in-range msrs, rare sweeps and bad codes
  task automatic send_random(int unsigned count);
    logic [2:0] op;
    logic [1:0] halves;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      if (pick < 2) op = OP_ALL;
      else if (pick < 4) op = OP_RESET;
      else if (pick < 7) op = OP_FIRST_UNUSED + 3'($urandom_range(0, 2));
      else if (pick < 37) op = OP_SET;
      else if (pick < 57) op = OP_CLEAR;
      else op = OP_LOOKUP;
      halves = ($urandom_range(0, 9) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
      issue(op, pick_msr(), halves[1], halves[0]);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    sender_idle_pct = 21;

    // directed: range edges, every operation, rejects and filter msrs
    issue(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1);
    issue(OP_SET, 32'h0000_0000, 1'b1, 1'b1);
    issue(OP_SET, 32'h0000_1FFF, 1'b1, 1'b0);
    issue(OP_SET, 32'hC000_0000, 1'b0, 1'b1);
    issue(OP_SET, 32'hC000_1FFF, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'h0000_0000, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'h0000_1FFF, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'hC000_0000, 1'b1, 1'b0);
    issue(OP_CLEAR, 32'h0000_1FFF, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'h0000_1FFF, 1'b1, 1'b1);
    issue(OP_SET, 32'h0000_2000, 1'b1, 1'b0);
    issue(OP_LOOKUP, 32'hBFFF_FFFF, 1'b1, 1'b1);
    issue(OP_SET, 32'hC000_2000, 1'b0, 1'b1);
    issue(OP_LOOKUP, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue(OP_SET, 32'h0000_0005, 1'b0, 1'b0);
    for (int k = OP_FIRST_UNUSED; k <= OP_LAST_UNUSED; k++)
      issue(3'(k), 32'h0000_0005, 1'b1, 1'b1);
    // msr number is ignored by intercept all
    issue(OP_ALL, 32'hFFFF_FFFF, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'h0000_00E7, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'h0000_0048, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'hC000_0102, 1'b1, 1'b1);
    issue(OP_LOOKUP, 32'hC000_1FFF, 1'b1, 1'b1);
    issue(OP_RESET, 32'h0000_0000, 1'b0, 1'b1);
    issue(OP_LOOKUP, 32'h0000_0100, 1'b1, 1'b1);
    issue(OP_RESET, 32'hFFFF_FFFF, 1'b1, 1'b0);
    issue(OP_ALL, 32'h0000_0000, 1'b0, 1'b0);

    // random phases: light idling, heavy idling, back to back
    send_random(PHASE_ITEMS);
    sender_idle_pct = 79;
    send_random(PHASE_ITEMS);
    sender_idle_pct = 0;
    send_random(PHASE_ITEMS);
    start <= 1'b0;

    // drain outstanding results
    while (tracker.pending_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.pending_replies.size() == 0)
      $display("** msr_intercept_bitmap_manager: PASSED **");
    else
      $display("** msr_intercept_bitmap_manager: FAILED **");
    $finish;
  end

endmodule

// File: filelist.f
hdl/mib_pkg.sv
hdl/mib_ctrl.sv
hdl/mib_datapath.sv
hdl/msr_intercept_bitmap_manager.sv
bench/msr_intercept_bitmap_manager_test.sv
